/* sv/fss_pkg.sv */
// Shared types, codes and constants of the failover server selector.
package fss_pkg;

  localparam int unsigned NUM_SRV = 8;
  localparam int unsigned SRV_W   = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned FC_W    = 8;
  localparam int unsigned CD_W    = 19;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned PRIO_W  = 4;
  localparam int unsigned TBL_W   = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [FC_W-1:0]   FC_MAX       = 8'hFF;
  localparam logic [SRV_W-1:0]  MULT_CAP     = 3'd5;
  localparam logic [FC_W-1:0]   UNHEALTHY_AT = 8'd3;
  localparam logic [CNT_W-1:0]  RST_SERVER_COUNT = 4'd8;
  localparam logic [BASE_W-1:0] RST_BASE_COOLDOWN = 16'd30;

  typedef enum logic [OP_W-1:0] {
    OP_SELECT         = 3'd0,
    OP_SUCCESS        = 3'd1,
    OP_FAILURE        = 3'd2,
    OP_MARK_UNHEALTHY = 3'd3,
    OP_MARK_HEALTHY   = 3'd4,
    OP_RESET_ALL      = 3'd5,
    OP_TICK           = 3'd6
  } fss_op_e;

  typedef enum logic [1:0] {
    REG_STRATEGY      = 2'd0,
    REG_SERVER_COUNT  = 2'd1,
    REG_BASE_COOLDOWN = 2'd2,
    REG_PRIORITY      = 2'd3
  } fss_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_EXEC,
    ST_FINISH
  } fss_state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SRV_W-1:0] server;
  } fss_in_t;

  typedef struct packed {
    logic [SRV_W-1:0] selected;
    logic             selected_valid;
    logic             forced;
    logic             server_known;
    logic [CNT_W-1:0] healthy_total;
    logic             any_available;
  } fss_out_t;

  typedef struct packed {
    logic              strategy;
    logic [CNT_W-1:0]  server_count;
    logic [BASE_W-1:0] base_cooldown;
    logic [TBL_W-1:0]  priority_table;
  } fss_cfg_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic scan_step;
    logic exec;
    logic finish;
  } fss_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic idx_ge_n;
    logic scan_last;
  } fss_sts_t;

  function automatic logic [PRIO_W-1:0] prio_of(input logic [TBL_W-1:0] tbl,
                                                 input logic [SRV_W-1:0] k);
    return tbl[{k, 2'b00} +: PRIO_W];
  endfunction

endpackage

/* sv/fss_cfg.sv */
// APB configuration registers of the failover server selector.
module fss_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fss_pkg::ADDR_W-1:0]         paddr,
  input  logic [fss_pkg::DATA_W-1:0]         pwdata,
  output logic [fss_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  output fss_pkg::fss_cfg_t                  cfg_o
);

  fss_pkg::fss_cfg_t cfg_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strategy       <= 1'b0;
      cfg_q.server_count   <= fss_pkg::RST_SERVER_COUNT;
      cfg_q.base_cooldown  <= fss_pkg::RST_BASE_COOLDOWN;
      cfg_q.priority_table <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        fss_pkg::REG_STRATEGY:      cfg_q.strategy       <= pwdata[0];
        fss_pkg::REG_SERVER_COUNT:  cfg_q.server_count   <= pwdata[fss_pkg::CNT_W-1:0];
        fss_pkg::REG_BASE_COOLDOWN: cfg_q.base_cooldown  <= pwdata[fss_pkg::BASE_W-1:0];
        fss_pkg::REG_PRIORITY:      cfg_q.priority_table <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fss_pkg::REG_STRATEGY:      prdata = {31'b0, cfg_q.strategy};
      fss_pkg::REG_SERVER_COUNT:  prdata = {28'b0, cfg_q.server_count};
      fss_pkg::REG_BASE_COOLDOWN: prdata = {16'b0, cfg_q.base_cooldown};
      fss_pkg::REG_PRIORITY:      prdata = cfg_q.priority_table;
      default:                    prdata = '0;
    endcase
  end

endmodule

/* sv/fss_ctrl.sv */
// Controller state machine of the failover server selector.
module fss_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fss_pkg::OP_W-1:0]    op_i,
  input  fss_pkg::fss_sts_t           sts_i,
  output logic                        busy_o,
  output logic                        done_o,
  output fss_pkg::fss_cmd_t           cmd_o
);

  fss_pkg::fss_state_e state_q, state_d;
  logic                done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fss_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      fss_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (op_i == fss_pkg::OP_SELECT) begin
            state_d = sts_i.n_zero ? fss_pkg::ST_FINISH : fss_pkg::ST_MOD;
          end else begin
            state_d = fss_pkg::ST_EXEC;
          end
        end
      end
      fss_pkg::ST_MOD: begin
        // reduce the start index below the count in use
        if (sts_i.idx_ge_n) begin
          cmd_o.mod_step = 1'b1;
        end else begin
          state_d = fss_pkg::ST_SCAN;
        end
      end
      fss_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = fss_pkg::ST_FINISH;
        end
      end
      fss_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = fss_pkg::ST_FINISH;
      end
      fss_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        state_d      = fss_pkg::ST_IDLE;
      end
      default: state_d = fss_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != fss_pkg::ST_IDLE);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe lasted more than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted transaction left block idle");
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fss_pkg::ST_SCAN) |-> !sts_i.n_zero)
    else $error("scan entered with no servers in use");
`endif

endmodule

/* sv/fss_dp.sv */
// Datapath of the failover server selector: server table, scan trackers, result.
module fss_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fss_pkg::fss_in_t  item_i,
  input  fss_pkg::fss_cfg_t cfg_i,
  input  fss_pkg::fss_cmd_t cmd_i,
  output fss_pkg::fss_sts_t sts_o,
  output fss_pkg::fss_out_t result_o
);

  localparam int unsigned SW = fss_pkg::SRV_W;
  localparam int unsigned CW = fss_pkg::CNT_W;
  localparam int unsigned FW = fss_pkg::FC_W;
  localparam int unsigned DW = fss_pkg::CD_W;
  localparam int unsigned PW = fss_pkg::PRIO_W;

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] k,
                                             input logic [CW-1:0] n);
    logic [CW-1:0] nxt;
    nxt = {1'b0, k} + CW'(1);
    return (nxt == n) ? '0 : nxt[SW-1:0];
  endfunction

  // server table
  logic          healthy_q [fss_pkg::NUM_SRV];
  logic [FW-1:0] fc_q      [fss_pkg::NUM_SRV];
  logic [DW-1:0] cd_q      [fss_pkg::NUM_SRV];
  logic [SW-1:0] rr_q;

  // transaction and scan registers
  logic [fss_pkg::OP_W-1:0] op_q;
  logic [SW-1:0] srv_q, idx_q, cnt_q;
  logic          hf_q, af_q;
  logic [SW-1:0] hk_q, ak_q, pk_q, mk_q;
  logic [PW-1:0] pb_q;
  logic [DW-1:0] mcd_q;
  fss_pkg::fss_out_t result_q;

  logic [CW-1:0] n_use;
  logic [SW-1:0] rd_idx;
  logic          rd_h, avail, known;
  logic [FW-1:0] rd_fc, fc_inc;
  logic [DW-1:0] rd_cd, cd_fail;
  logic [SW-1:0] mult;
  logic [PW-1:0] pr;
  logic          wr_en, wr_h;
  logic [FW-1:0] wr_fc;
  logic [DW-1:0] wr_cd;
  logic [SW-1:0] sel_w;
  logic          valid_w, forced_w, known_w, avail_w;
  logic [CW-1:0] htot_w;

  assign n_use = (cfg_i.server_count > CW'(fss_pkg::NUM_SRV)) ?
                 CW'(fss_pkg::NUM_SRV) : cfg_i.server_count;

  assign sts_o.n_zero    = (n_use == '0);
  assign sts_o.idx_ge_n  = ({1'b0, idx_q} >= n_use);
  assign sts_o.scan_last = ({1'b0, cnt_q} == (n_use - CW'(1)));

  // table read port: addressed server during exec, scan index otherwise
  assign rd_idx = cmd_i.exec ? srv_q : idx_q;
  assign rd_h   = healthy_q[rd_idx];
  assign rd_fc  = fc_q[rd_idx];
  assign rd_cd  = cd_q[rd_idx];
  assign avail  = (rd_cd == '0);
  assign pr     = fss_pkg::prio_of(cfg_i.priority_table, idx_q);
  assign known  = ({1'b0, srv_q} < n_use);

  assign fc_inc  = (rd_fc == fss_pkg::FC_MAX) ? rd_fc : rd_fc + FW'(1);
  assign mult    = (fc_inc < FW'(fss_pkg::MULT_CAP)) ? fc_inc[SW-1:0] : fss_pkg::MULT_CAP;
  assign cd_fail = DW'(cfg_i.base_cooldown) * DW'(mult);

  always_comb begin
    wr_en = 1'b0;
    wr_h  = rd_h;
    wr_fc = rd_fc;
    wr_cd = rd_cd;
    case (op_q)
      fss_pkg::OP_SUCCESS: begin
        wr_en = 1'b1;
        wr_h  = 1'b1;
        wr_fc = '0;
        wr_cd = '0;
      end
      fss_pkg::OP_FAILURE: begin
        wr_en = 1'b1;
        wr_fc = fc_inc;
        wr_cd = cd_fail;
        if (fc_inc >= fss_pkg::UNHEALTHY_AT) wr_h = 1'b0;
      end
      fss_pkg::OP_MARK_UNHEALTHY: begin
        wr_en = 1'b1;
        wr_h  = 1'b0;
      end
      fss_pkg::OP_MARK_HEALTHY: begin
        wr_en = 1'b1;
        wr_h  = 1'b1;
        wr_cd = '0;
      end
      default: wr_en = 1'b0;
    endcase
    wr_en = wr_en & cmd_i.exec & known;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fss_pkg::NUM_SRV; i++) begin
        healthy_q[i] <= 1'b1;
        fc_q[i]      <= '0;
        cd_q[i]      <= '0;
      end
    end else begin
      for (int i = 0; i < fss_pkg::NUM_SRV; i++) begin
        if (cmd_i.exec && op_q == fss_pkg::OP_RESET_ALL) begin
          healthy_q[i] <= 1'b1;
          fc_q[i]      <= '0;
          cd_q[i]      <= '0;
        end else if (cmd_i.exec && op_q == fss_pkg::OP_TICK) begin
          if (cd_q[i] != '0) cd_q[i] <= cd_q[i] - DW'(1);
        end else if (wr_en && srv_q == SW'(i)) begin
          healthy_q[i] <= wr_h;
          fc_q[i]      <= wr_fc;
          cd_q[i]      <= wr_cd;
        end
      end
    end
  end

  // scan: rotate from the pointer, track first healthy free, first free,
  // best priority among free and smallest countdown (ties to lowest index)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= '0;
      srv_q <= '0;
      idx_q <= '0;
      cnt_q <= '0;
      hf_q  <= 1'b0;
      af_q  <= 1'b0;
    end else if (cmd_i.load) begin
      op_q  <= item_i.op;
      srv_q <= item_i.server;
      idx_q <= rr_q;
      cnt_q <= '0;
      hf_q  <= 1'b0;
      af_q  <= 1'b0;
    end else if (cmd_i.mod_step) begin
      idx_q <= idx_q - n_use[SW-1:0];
    end else if (cmd_i.scan_step) begin
      idx_q <= wrap_inc(idx_q, n_use);
      cnt_q <= cnt_q + SW'(1);
      if (avail && rd_h && !hf_q) begin
        hf_q <= 1'b1;
      end
      if (avail) begin
        af_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      if (avail && rd_h && !hf_q) hk_q <= idx_q;
      if (avail && !af_q) ak_q <= idx_q;
      if (avail && (!af_q || pr < pb_q || (pr == pb_q && idx_q < pk_q))) begin
        pk_q <= idx_q;
        pb_q <= pr;
      end
      if (cnt_q == '0 || rd_cd < mcd_q || (rd_cd == mcd_q && idx_q < mk_q)) begin
        mk_q  <= idx_q;
        mcd_q <= rd_cd;
      end
    end
  end

  always_comb begin
    sel_w    = '0;
    valid_w  = 1'b0;
    forced_w = 1'b0;
    htot_w   = '0;
    avail_w  = 1'b0;
    if (op_q == fss_pkg::OP_SELECT && n_use != '0) begin
      valid_w = 1'b1;
      if (!cfg_i.strategy && hf_q) begin
        sel_w = hk_q;
      end else if (!cfg_i.strategy && af_q) begin
        sel_w = ak_q;
      end else if (cfg_i.strategy && af_q) begin
        sel_w = pk_q;
      end else begin
        sel_w    = mk_q;
        forced_w = 1'b1;
      end
    end
    known_w = known && (op_q == fss_pkg::OP_SUCCESS || op_q == fss_pkg::OP_FAILURE ||
              op_q == fss_pkg::OP_MARK_UNHEALTHY || op_q == fss_pkg::OP_MARK_HEALTHY);
    for (int i = 0; i < fss_pkg::NUM_SRV; i++) begin
      if (CW'(i) < n_use) begin
        htot_w = htot_w + CW'(healthy_q[i]);
        if (cd_q[i] == '0) avail_w = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q     <= '0;
      result_q <= '0;
    end else if (cmd_i.finish) begin
      if (valid_w && !forced_w && !cfg_i.strategy) begin
        rr_q <= wrap_inc(sel_w, n_use);
      end
      result_q.selected       <= sel_w;
      result_q.selected_valid <= valid_w;
      result_q.forced         <= forced_w;
      result_q.server_known   <= known_w;
      result_q.healthy_total  <= htot_w;
      result_q.any_available  <= avail_w;
    end
  end

  assign result_o = result_q;

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> ({1'b0, idx_q} < n_use))
    else $error("scan index beyond servers in use");
  a_forced_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_q.forced |-> result_q.selected_valid)
    else $error("forced choice without a selection");
`endif

endmodule

/* sv/failover_server_selector.sv */
// Top level of the failover server selector: config port, controller, datapath.
//
// Usage: a command transaction (item_i.op, item_i.server) is accepted at a
// rising edge with start high and busy low. Ops: select, success, failure,
// mark unhealthy, mark healthy, reset all, tick. Every command yields exactly
// one result on result_o, valid for the single cycle in which done_o is high;
// the receiver cannot stall, so sample result_o whenever done_o is set.
// Sequence: a select loads the command, scans the servers in use and then
// registers the result; the datapath reads one table entry per cycle while
// the controller walks the scan. When server_count has shrunk below the round
// robin pointer, the start index is first reduced by one subtraction a cycle.
// A select with no servers in use skips the scan. Every other command passes
// one execute step (one read-modify-write of the addressed entry, or a
// whole-table clear/decrement) before the result is registered.
// busy drops in the cycle done_o rises, so a new start is taken then.
// Configuration: APB writes at byte addresses 0 (strategy), 4 (server_count),
// 8 (base_cooldown), 12 (priority_table); write only while idle.
// Reset: all servers healthy, zero failure counts and cooldowns, pointer zero,
// registers at their defaults; the block is ready in the first cycle after it.
module failover_server_selector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  fss_pkg::fss_in_t           item_i,
  output logic                       done_o,
  output fss_pkg::fss_out_t          result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fss_pkg::ADDR_W-1:0] paddr,
  input  logic [fss_pkg::DATA_W-1:0] pwdata,
  output logic [fss_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  fss_pkg::fss_cfg_t cfg;
  fss_pkg::fss_cmd_t cmd;
  fss_pkg::fss_sts_t sts;

  // hold the configuration registers
  fss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequence each transaction: load, optional index reduction, scan or execute
  // (skipped by a select with no servers in use), then register the result
  fss_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (item_i.op),
    .sts_i   (sts),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // hold the server table and compute the selection
  fss_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule
